FILE: design/clir_pkg.sv
// ----------------------------------------------------------------------------
// clir_pkg: shared types and codes for the cursor list
// Holds the command and result word layouts, the opcode codes and the
// shift control word that the top level broadcasts to every cell.
// ----------------------------------------------------------------------------
package clir_pkg;

  // Operation codes carried in the command word.
  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_END     = 3'd1;
  localparam logic [2:0] OP_ADVANCE = 3'd2;
  localparam logic [2:0] OP_BACK    = 3'd3;
  localparam logic [2:0] OP_ADD     = 3'd4;
  localparam logic [2:0] OP_REMOVE  = 3'd5;
  localparam logic [2:0] OP_READ    = 3'd6;

  // Command word: one operation.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] entry_value;
  } cmd_t;

  // Result word: list status after the operation.
  typedef struct packed {
    logic [31:0] current_value;
    logic        has_current;
    logic [5:0]  item_count;
    logic        op_error;
  } res_t;

  // Shift control broadcast along the row of cells.
  typedef struct packed {
    logic ins;  // open a gap and load the new value at the insert position
    logic rem;  // close the gap at the removal position
  } shift_t;

endpackage

FILE: design/cursor_list_insert_remove.sv
// Sequence: an accepted command sets busy; the result word, marked by done,
// is registered while busy, and busy stays high until done rises.
// Issue: a new command is taken only while busy is low; each command needs
// the slot update cycle and then the read cycle that selects the cell's value.
// Reset: rst, synchronous, empties the list and parks the cursor at slot 0.
// The receiver cannot stall; each result word is marked by done for one cycle.
// ----------------------------------------------------------------------------
// cursor_list_insert_remove: bounded ordered list with a cursor
// A row of cells holds the items; inserts and removals shift the cells at and
// past pos in parallel. Count and cursor live here and drive the shift control.
// ----------------------------------------------------------------------------
module cursor_list_insert_remove import clir_pkg::*; #(
  parameter int DEPTH     = 32,
  parameter int ITEM_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output res_t result
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]     count, count_next;
  logic [CNT_W-1:0]     cursor, cursor_next;
  logic                 err, err_next;
  logic                 accept;
  logic                 cur_valid;
  shift_t               ctl;
  logic [CNT_W-1:0]     pos;
  logic [ITEM_BITS-1:0] entry;
  logic [ITEM_BITS+31:0] entry_ext;
  logic [ITEM_BITS-1:0] cell_val [DEPTH];
  logic [ITEM_BITS-1:0] cell_rd  [DEPTH];
  logic [ITEM_BITS-1:0] rd_any;
  logic [ITEM_BITS+31:0] rd_ext;
  logic [CNT_W+5:0]     count_ext;

  assign accept    = start && !busy;
  assign cur_valid = (cursor < count);
  assign entry_ext = {{ITEM_BITS{1'b0}}, cmd.entry_value};
  assign entry     = entry_ext[ITEM_BITS-1:0];

  // Operation decode: next count and cursor, shift control and error flag.
  always_comb begin
    count_next  = count;
    cursor_next = cursor;
    err_next    = 1'b0;
    ctl         = '0;
    pos         = cursor;
    case (cmd.opcode)
      OP_START: begin
        cursor_next = '0;
      end
      OP_END: begin
        cursor_next = (count != '0) ? count - CNT_W'(1) : '0;
      end
      OP_ADVANCE: begin
        if (!cur_valid) err_next = 1'b1;
        else cursor_next = cursor + CNT_W'(1);
      end
      OP_BACK: begin
        if (!cur_valid) err_next = 1'b1;
        else if (cursor == '0) cursor_next = count;
        else cursor_next = cursor - CNT_W'(1);
      end
      OP_ADD: begin
        pos = cur_valid ? cursor + CNT_W'(1) : '0;
        if (count == CNT_W'(DEPTH)) begin
          err_next = 1'b1;
        end else begin
          ctl.ins     = accept;
          cursor_next = pos;
          count_next  = count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!cur_valid) begin
          err_next = 1'b1;
        end else begin
          ctl.rem    = accept;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers and the command sequence (busy, then done).
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      cursor <= '0;
      busy   <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= busy;
      busy <= accept;
      if (accept) begin
        count  <= count_next;
        cursor <= cursor_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err <= err_next;
    end
  end

  // Row of slot cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ITEM_BITS-1:0] left_v;
    logic [ITEM_BITS-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    clir_cell #(
      .ITEM_BITS (ITEM_BITS),
      .IDX_W     (CNT_W),
      .INDEX     (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (pos),
      .entry     (entry),
      .left_val  (left_v),
      .right_val (right_v),
      .rd_index  (cursor),
      .val       (cell_val[i]),
      .rd_val    (cell_rd[i])
    );
  end

  // Combine the gated cell outputs into the current value.
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  assign rd_ext    = {32'b0, rd_any};
  assign count_ext = {6'b0, count};

  // Result word register, loaded in the read cycle.
  always_ff @(posedge clk) begin
    if (busy) begin
      result.current_value <= cur_valid ? rd_ext[31:0] : 32'b0;
      result.has_current   <= cur_valid;
      result.item_count    <= count_ext[5:0];
      result.op_error      <= err;
    end
  end

endmodule

FILE: design/clir_cell.sv
// ----------------------------------------------------------------------------
// clir_cell: one slot of the list
// Holds one stored item. Insert loads the new value at the position and the
// left neighbor's value past it; remove loads the right neighbor's value at
// or past it. It drives the read bus with its value when rd_index matches.
// ----------------------------------------------------------------------------
module clir_cell import clir_pkg::*; #(
  parameter int ITEM_BITS = 32,
  parameter int IDX_W     = 6,
  parameter int INDEX     = 0
) (
  input  logic                 clk,
  input  shift_t               ctl,
  input  logic [IDX_W-1:0]     pos,
  input  logic [ITEM_BITS-1:0] entry,
  input  logic [ITEM_BITS-1:0] left_val,
  input  logic [ITEM_BITS-1:0] right_val,
  input  logic [IDX_W-1:0]     rd_index,
  output logic [ITEM_BITS-1:0] val,
  output logic [ITEM_BITS-1:0] rd_val
);

  logic [IDX_W-1:0] my_index;
  logic             at_pos;
  logic             past_pos;

  assign my_index = IDX_W'(INDEX);
  assign at_pos   = (my_index == pos);
  assign past_pos = (my_index > pos);

  // Slot update: insert shifts right of the position, remove shifts left.
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (at_pos) begin
        val <= entry;
      end else if (past_pos) begin
        val <= left_val;
      end
    end else if (ctl.rem) begin
      if (at_pos || past_pos) begin
        val <= right_val;
      end
    end
  end

  // Gated read onto the shared OR bus.
  assign rd_val = (rd_index == my_index) ? val : '0;

endmodule
